// ----- rtl/spf_pkg.sv -----
`default_nettype none
package spf_pkg;

	localparam int PAT_BYTES = 16;
	localparam int LEN_W     = 5;
	localparam int POS_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2,
		REG_FOLD     = 2'd3
	} cfg_reg_t;

	localparam logic [7:0] ASCII_LC_A   = 8'h61;
	localparam logic [7:0] ASCII_LC_Z   = 8'h7a;
	localparam logic [7:0] ASCII_CASE_D = 8'h20;

	// upper-case a..z when folding is on; everything else passes unchanged
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
		logic [7:0] r;
		r = b;
		if (en && b >= ASCII_LC_A && b <= ASCII_LC_Z) begin
			r = b - ASCII_CASE_D;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/stream_pattern_finder_core.sv -----
// Streaming search for the first occurrence of a pattern of up to 16 bytes in a buffer
// delivered one byte per item, with last_byte marking the end of the buffer. One item is
// accepted every cycle while the result side keeps up. An accepted byte is held in an input
// stage, where the window shift and all candidate-length compares are done in parallel;
// the result (if any) is then captured in the output register that drives found/match_start.
// Each buffer gives exactly one result: found=1 with the start offset at the byte that
// completes the first match, or found=0 with offset 0 at the last byte. Bytes after a
// match are consumed silently. The output register is a full stage: new bytes keep
// flowing while a result is held, until a second result would be needed. Patterns are
// set through cfg_write/cfg_index/cfg_data (low bytes, high bytes, length, fold_case)
// while the block is idle, a rule for the user that the block does not enforce. A length
// of zero never matches; lengths above min(MAX_PATTERN_BYTES, 16) are clipped to that.
`default_nettype none
module stream_pattern_finder_core #(
	parameter int MAX_PATTERN_BYTES = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [spf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [spf_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      data_byte,
	input  wire logic                            last_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 found,
	output logic [spf_pkg::POS_W-1:0]            match_start
);
	import spf_pkg::*;

	localparam int WIN_DEPTH = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(WIN_DEPTH);
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// configuration
	logic [CFG_W-1:0]       pat_low_q;
	logic [CFG_W-1:0]       pat_high_q;
	logic [LEN_W-1:0]       pat_len_q;
	logic                   fold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
			fold_q     <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PAT_LOW:  pat_low_q  <= cfg_data;
				REG_PAT_HIGH: pat_high_q <= cfg_data;
				REG_PAT_LEN:  pat_len_q  <= cfg_data[LEN_W-1:0];
				REG_FOLD:     fold_q     <= cfg_data[0];
				default:      pat_low_q  <= pat_low_q;
			endcase
		end
	end

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;
	logic       res_gen;

	// an item with no result may pass while a result is still held
	assign adv_s1   = valid_s1 && (!res_gen || !out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// buffer state
	logic [7:0]       win_q [WIN_DEPTH];
	logic [POS_W-1:0] pos_q;
	logic             found_q;

	logic [7:0]           win_next [WIN_DEPTH];
	logic [7:0]           win_f    [WIN_DEPTH];
	logic [7:0]           pat_f    [PAT_BYTES];
	logic [2*CFG_W-1:0]   pat_all;
	logic [PAT_BYTES:0]   hit_vec;
	logic [LEN_W-1:0]     len_eff;
	logic [POS_W-1:0]     seen;
	logic                 hit;
	logic                 res_hit;
	logic                 res_miss;

	assign pat_all = {pat_high_q, pat_low_q};
	assign len_eff = (pat_len_q > LEN_CAP) ? LEN_CAP : pat_len_q;
	assign seen    = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_comb begin
		win_next[0] = byte_s1;
		for (int i = 1; i < WIN_DEPTH; i++) begin
			win_next[i] = win_q[i-1];
		end
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_f[i] = fold_byte(win_next[i], fold_q);
		end
		for (int k = 0; k < PAT_BYTES; k++) begin
			pat_f[k] = fold_byte(pat_all[8*k +: 8], fold_q);
		end
	end

	// one compare tree per candidate length; pattern byte k lines up with window l-1-k
	always_comb begin
		hit_vec = '0;
		for (int l = 1; l <= PAT_BYTES; l++) begin
			if (l <= WIN_DEPTH) begin
				hit_vec[l] = 1'b1;
				for (int k = 0; k < PAT_BYTES; k++) begin
					if (k < l) begin
						hit_vec[l] = hit_vec[l] && (win_f[l-1-k] == pat_f[k]);
					end
				end
			end
		end
	end

	assign hit      = hit_vec[len_eff] && (seen >= POS_W'(len_eff));
	assign res_hit  = !found_q && hit;
	assign res_miss = last_s1 && !found_q && !hit;
	assign res_gen  = res_hit || res_miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q   <= '0;
				found_q <= 1'b0;
			end else begin
				pos_q   <= seen;
				found_q <= found_q || hit;
			end
		end
	end

	// stale bytes of an earlier buffer stay in the window; the seen >= len check masks them
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && res_gen) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_gen) begin
			found       <= res_hit;
			match_start <= res_hit ? (seen - POS_W'(len_eff)) : '0;
		end
	end

	a_found_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> pos_q != '0)
		else $error("found flag set with no bytes seen");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled without a held result");

	a_one_result_per_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && found_q |-> !res_gen)
		else $error("second result in one buffer");

	a_miss_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_start == '0)
		else $error("not-found result with nonzero offset");

endmodule
`default_nettype wire
